[rtl/core/iblt_pkg.sv]
// Package with the shared constants, types and index hash of the lookup table.
package iblt_pkg;

    localparam int NUM_TABLES        = 4;
    localparam int BUCKETS_PER_TABLE = 256;
    localparam int COUNT_BITS        = 16;

    localparam int TOTAL_BUCKETS = NUM_TABLES * BUCKETS_PER_TABLE;
    localparam int ADDR_W        = $clog2(TOTAL_BUCKETS);
    localparam int IDX_W         = $clog2(BUCKETS_PER_TABLE);
    localparam int T_W           = $clog2(NUM_TABLES);
    localparam int SINCE_W       = ADDR_W + 1;
    localparam int NZ_W          = ADDR_W + 1;
    localparam int COEFF_W       = 62;
    localparam int HALF_W        = 31;
    localparam int CFG_IDX_W     = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_PEEL   = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_PEELED   = 2'd1;
    localparam logic [1:0] ST_SUCCESS  = 2'd2;
    localparam logic [1:0] ST_FAILURE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE3 = 3'd4;

    typedef struct packed {
        logic               opcode;
        logic signed [63:0] key_in;
    } iblt_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] key_out;
    } iblt_out_t;

    typedef struct packed {
        logic [63:0]           key_sum;
        logic [63:0]           check_sum;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Low bits of the affine index hash; only the low slices of the operands matter.
    function automatic logic [IDX_W-1:0] index_hash_low(input logic [COEFF_W-1:0] coeffs,
                                                        input logic [63:0] key);
        logic [IDX_W-1:0]   a;
        logic [IDX_W-1:0]   b;
        logic [2*IDX_W-1:0] p;
        a = coeffs[HALF_W +: IDX_W];
        b = coeffs[IDX_W-1:0];
        p = a * key[IDX_W-1:0];
        return p[IDX_W-1:0] + b;
    endfunction

endpackage

[rtl/core/iblt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module iblt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/iblt_hash.sv]
// Check hash unit: a*key+b mod 2^64 with one shared 31x32 multiplier.
module iblt_hash
    import iblt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COEFF_W-1:0] coeffs,
    input  logic [63:0]        key,
    output logic               hash_valid,
    output logic [63:0]        hash
);

    logic [HALF_W-1:0] a_reg;
    logic [HALF_W-1:0] b_reg;
    logic [63:0]       key_reg;
    logic [62:0]       p0_reg;
    logic [31:0]       p1_reg;
    logic [63:0]       hash_reg;
    logic [1:0]        step_reg;
    logic [1:0]        step_next;
    logic [31:0]       mul_b;
    logic [62:0]       prod;
    logic              valid_flag_reg;

    assign mul_b = (step_reg == 2'd1) ? key_reg[31:0] : key_reg[63:32];
    assign prod  = a_reg * mul_b;

    always_comb
    begin
        step_next = step_reg;
        if (start)
        begin
            step_next = 2'd1;
        end
        else if (step_reg != 2'd0)
        begin
            step_next = (step_reg == 2'd3) ? 2'd0 : step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= coeffs[COEFF_W-1:HALF_W];
            b_reg   <= coeffs[HALF_W-1:0];
            key_reg <= key;
        end
        if (step_reg == 2'd1)
        begin
            p0_reg <= prod;
        end
        if (step_reg == 2'd2)
        begin
            p1_reg <= prod[31:0];
        end
        if (step_reg == 2'd3)
        begin
            hash_reg <= {1'b0, p0_reg} + {p1_reg, 32'h0} + {33'h0, b_reg};
        end
    end

    assign hash       = hash_reg;
    assign hash_valid = (step_reg == 2'd0) && !start && valid_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_flag_reg <= 1'b0;
        end
        else
        begin
            valid_flag_reg <= (step_reg == 2'd3);
        end
    end

endmodule

[rtl/core/iblt_insert_and_peel.sv]
// Top level of the invertible Bloom lookup table with insert and peel-next.
//
// Input channel (in_valid, in_stall, in_data): each beat is an insert (key_in)
// or a peel-next request. Output channel (out_valid, out_stall, out_data):
// exactly one result beat per input beat, in order.
// An insert runs the check hash, then a read-modify-write of one bucket
// in each subtable. A peel scans buckets one by one, check hashing each
// bucket whose count is one; a peeled key is then removed from one bucket
// per subtable. A peel may thus scan up to the whole table, since the
// single bucket memory port serves one bucket at a time. Once a full pass
// finds nothing, a peel answers without scanning, from a running count of
// nonzero buckets.
// After reset the block runs a clearing pass over all TOTAL_BUCKETS (1024)
// buckets of the bucket memory and stalls its input until that is done.
// Configuration writes (cfg_we, cfg_index, cfg_data) belong in cycles with no
// beat in flight, since the hashes read the registers while a beat is worked.
// A result waits in the output register while out_stall is high; the block
// then holds the next finished result until the register frees up.
module iblt_insert_and_peel
    import iblt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  iblt_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output iblt_out_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEFF_W-1:0]   cfg_data
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_HW   = 4'd2;
    localparam logic [3:0] S_URD  = 4'd3;
    localparam logic [3:0] S_UWR  = 4'd4;
    localparam logic [3:0] S_PRD  = 4'd5;
    localparam logic [3:0] S_PEX  = 4'd6;
    localparam logic [3:0] S_PHW  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(TOTAL_BUCKETS - 1);
    localparam logic [SINCE_W-1:0] SINCE_MAX = SINCE_W'(TOTAL_BUCKETS);

    // Configuration registers.
    logic [COEFF_W-1:0] chk_coef_reg;
    logic [COEFF_W-1:0] tbl_coef_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_coef_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                tbl_coef_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHECK:  chk_coef_reg    <= cfg_data;
                CFG_TABLE0: tbl_coef_reg[0] <= cfg_data;
                CFG_TABLE1: tbl_coef_reg[1] <= cfg_data;
                CFG_TABLE2: tbl_coef_reg[2] <= cfg_data;
                CFG_TABLE3: tbl_coef_reg[3] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Control and working registers.
    logic [3:0]         state_reg, state_next;
    logic               op_reg, op_next;
    logic [63:0]        key_reg, key_next;
    logic [63:0]        chk_reg, chk_next;
    logic [T_W-1:0]     t_reg, t_next;
    logic [ADDR_W-1:0]  scan_reg, scan_next;
    logic [SINCE_W-1:0] since_reg, since_next;
    logic [NZ_W-1:0]    nz_reg, nz_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [1:0]         res_st_reg, res_st_next;
    logic               out_valid_reg, out_valid_next;
    iblt_out_t          out_reg, out_next;

    // Bucket memory and hash unit.
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    entry_t             mem_wdata, mem_rdata;
    logic               hash_start;
    logic [63:0]        hash_key;
    logic               hash_valid;
    logic [63:0]        hash_val;

    iblt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL_BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    iblt_hash u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (hash_start),
        .coeffs     (chk_coef_reg),
        .key        (hash_key),
        .hash_valid (hash_valid),
        .hash       (hash_val)
    );

    // Slot of the current key in the current subtable.
    logic [IDX_W-1:0]  cur_idx;
    logic [ADDR_W-1:0] cur_slot;
    assign cur_idx  = index_hash_low(tbl_coef_reg[t_reg], key_reg);
    assign cur_slot = ADDR_W'(t_reg) * ADDR_W'(BUCKETS_PER_TABLE) + ADDR_W'(cur_idx);

    logic [COUNT_BITS-1:0] new_count;
    logic                  exhaust_soon;
    logic [1:0]            done_status;
    assign new_count    = (op_reg == OP_INSERT) ? mem_rdata.count + 1'b1
                                                : mem_rdata.count - 1'b1;
    assign exhaust_soon = (since_reg + 1'b1) >= SINCE_MAX;
    assign done_status  = (nz_reg != '0) ? ST_FAILURE : ST_SUCCESS;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        chk_next       = chk_reg;
        t_next         = t_reg;
        scan_next      = scan_reg;
        since_next     = since_reg;
        nz_next        = nz_reg;
        clr_next       = clr_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_slot;
        mem_wdata      = '0;
        mem_raddr      = cur_slot;
        hash_start     = 1'b0;
        hash_key       = key_reg;

        case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = in_data.opcode;
                    key_next = in_data.key_in;
                    t_next   = '0;
                    if (in_data.opcode == OP_INSERT)
                    begin
                        hash_start = 1'b1;
                        hash_key   = in_data.key_in;
                        since_next = '0;
                        state_next = S_HW;
                    end
                    else if (since_reg >= SINCE_MAX)
                    begin
                        res_st_next = done_status;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_PRD;
                    end
                end
            end
            S_HW:
            begin
                if (hash_valid)
                begin
                    chk_next   = hash_val;
                    state_next = S_URD;
                end
            end
            S_URD:
            begin
                state_next = S_UWR;
            end
            S_UWR:
            begin
                // Read-modify-write of one bucket; no overlap, so no forwarding.
                mem_we              = 1'b1;
                mem_wdata.key_sum   = mem_rdata.key_sum ^ key_reg;
                mem_wdata.check_sum = mem_rdata.check_sum ^ chk_reg;
                mem_wdata.count     = new_count;
                if (mem_rdata.count == '0 && new_count != '0)
                begin
                    nz_next = nz_reg + 1'b1;
                end
                else if (mem_rdata.count != '0 && new_count == '0)
                begin
                    nz_next = nz_reg - 1'b1;
                end
                t_next = t_reg + 1'b1;
                if (t_reg == T_W'(NUM_TABLES - 1))
                begin
                    res_st_next = (op_reg == OP_INSERT) ? ST_INSERTED : ST_PEELED;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_URD;
                end
            end
            S_PRD:
            begin
                mem_raddr  = scan_reg;
                state_next = S_PEX;
            end
            S_PEX:
            begin
                scan_next = (scan_reg == LAST_ADDR) ? '0 : scan_reg + 1'b1;
                key_next  = mem_rdata.key_sum;
                chk_next  = mem_rdata.check_sum;
                if (mem_rdata.count == COUNT_BITS'(1))
                begin
                    hash_start = 1'b1;
                    hash_key   = mem_rdata.key_sum;
                    state_next = S_PHW;
                end
                else
                begin
                    since_next = since_reg + 1'b1;
                    if (exhaust_soon)
                    begin
                        res_st_next = done_status;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_PRD;
                    end
                end
            end
            S_PHW:
            begin
                if (hash_valid)
                begin
                    if (hash_val == chk_reg)
                    begin
                        since_next = '0;
                        t_next     = '0;
                        state_next = S_URD;
                    end
                    else
                    begin
                        since_next = since_reg + 1'b1;
                        if (exhaust_soon)
                        begin
                            res_st_next = done_status;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_PRD;
                        end
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_next.status  = res_st_reg;
                    out_next.key_out = (res_st_reg == ST_PEELED) ? key_reg : '0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            scan_reg      <= '0;
            since_reg     <= '0;
            nz_reg        <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            since_reg     <= since_next;
            nz_reg        <= nz_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        chk_reg    <= chk_next;
        t_reg      <= t_next;
        res_st_reg <= res_st_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[tb/tb_iblt_insert_and_peel.sv]
// Self-checking testbench for the invertible Bloom lookup table with insert and peel-next.
module tb_iblt_insert_and_peel;
    import iblt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    iblt_in_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    iblt_out_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEFF_W-1:0]   cfg_data;

    iblt_insert_and_peel u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the table, kept in step with every accepted input beat.
    logic [COEFF_W-1:0]    shadow_check_coeffs;
    logic [COEFF_W-1:0]    shadow_table_coeffs [4];
    logic [63:0]           shadow_key_sums     [TOTAL_BUCKETS];
    logic [63:0]           shadow_check_sums   [TOTAL_BUCKETS];
    logic [COUNT_BITS-1:0] shadow_counts       [TOTAL_BUCKETS];
    int                    shadow_scan;
    int                    shadow_since_peel;

    iblt_in_t  pending_beats [$];    // input beats waiting for the driver
    iblt_out_t expected_results [$]; // predicted results, oldest first

    int  fail_count;
    int  n_inserts, n_peeled, n_success, n_failure;
    bit  idle_enable;
    int  send_gap;
    int  recv_gap;
    int  hold_cycles;
    bit  hold_request;
    bit  hold_done;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Affine hash a*key+b modulo 2^64, with a and b packed in one 62-bit register.
    function automatic logic [63:0] affine_hash(input logic [COEFF_W-1:0] coeffs,
                                                input logic [63:0] key);
        logic [63:0] mul;
        logic [63:0] add;
        mul = {33'd0, coeffs[61:31]};
        add = {33'd0, coeffs[30:0]};
        return mul * key + add;
    endfunction

    function automatic int bucket_slot(input logic [63:0] key, input int tbl);
        logic [63:0] h;
        h = affine_hash(shadow_table_coeffs[tbl], key);
        return tbl * BUCKETS_PER_TABLE + int'(h % BUCKETS_PER_TABLE);
    endfunction

    // Xor the key and its check hash into one bucket per subtable; counts wrap.
    function automatic void toggle_key(input logic [63:0] key, input logic [63:0] chk,
                                       input bit add);
        int s;
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            s = bucket_slot(key, t);
            shadow_key_sums[s]   ^= key;
            shadow_check_sums[s] ^= chk;
            if (add)
                shadow_counts[s] = shadow_counts[s] + 1'b1;
            else
                shadow_counts[s] = shadow_counts[s] - 1'b1;
        end
    endfunction

    // Works out the result of one input beat and advances the shadow table.
    function automatic iblt_out_t table_result(input iblt_in_t beat);
        iblt_out_t   r;
        int          s;
        logic [63:0] k;
        r.status  = ST_INSERTED;
        r.key_out = '0;
        if (beat.opcode == OP_INSERT)
        begin
            toggle_key(beat.key_in, affine_hash(shadow_check_coeffs, beat.key_in), 1'b1);
            shadow_since_peel = 0;
            n_inserts++;
            return r;
        end
        while (shadow_since_peel < TOTAL_BUCKETS)
        begin
            s = shadow_scan;
            shadow_scan = (shadow_scan + 1) % TOTAL_BUCKETS;
            // Purity is judged on the bucket as it stands now, so no key comes out twice.
            if (shadow_counts[s] == 1 &&
                affine_hash(shadow_check_coeffs, shadow_key_sums[s]) == shadow_check_sums[s])
            begin
                k = shadow_key_sums[s];
                toggle_key(k, shadow_check_sums[s], 1'b0);
                shadow_since_peel = 0;
                r.status  = ST_PEELED;
                r.key_out = k;
                n_peeled++;
                return r;
            end
            shadow_since_peel++;
        end
        // A whole pass found nothing pure: success only if the table is empty.
        r.status = ST_SUCCESS;
        for (int i = 0; i < TOTAL_BUCKETS; i++)
        begin
            if (shadow_counts[i] != 0)
                r.status = ST_FAILURE;
        end
        if (r.status == ST_SUCCESS)
            n_success++;
        else
            n_failure++;
        return r;
    endfunction

    // Driver: beats come from pending_beats; the payload holds while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.insert(expected_results.size(), table_result(in_data));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    in_data  <= pending_beats[0];
                    pending_beats.delete(0);
                    in_valid <= 1'b1;
                    if (idle_enable && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 12);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat and decides its own stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        iblt_out_t exp_beat;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap    = 0;
            hold_cycles = 0;
            hold_done   = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with none expected: status %0d key %h",
                             $time, out_data.status, out_data.key_out);
                    fail_count++;
                end
                else
                begin
                    exp_beat = expected_results[0];
                    expected_results.delete(0);
                    if (out_data.status !== exp_beat.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_beat.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.key_out !== exp_beat.key_out)
                    begin
                        $display("%0t: key_out expected %h actual %h",
                                 $time, exp_beat.key_out, out_data.key_out);
                        fail_count++;
                    end
                end
            end
            // A long hold-off lets the block fill up and push back on its input.
            if (hold_request && !hold_done)
            begin
                hold_done   = 1'b1;
                hold_cycles = 3000;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_beat(input logic op, input logic [63:0] key);
        iblt_in_t b;
        b.opcode = op;
        b.key_in = key;
        pending_beats.insert(pending_beats.size(), b);
    endtask

    // Keys are mostly random, with the extremes of the signed range mixed in.
    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 11))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return '1;
            3: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        // Indexes past the last table register are ignored by the block.
        if (idx == CFG_CHECK)
            shadow_check_coeffs = val;
        else if (idx <= CFG_TABLE3)
            shadow_table_coeffs[idx - CFG_TABLE0] = val;
    endtask

    // Waits until every beat was sent and every result came back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    // A well-formed round: n_keys inserts, then two more peels than inserts.
    task automatic push_round(input int n_keys);
        logic [63:0] keys [$];
        logic [63:0] k;
        for (int i = 0; i < n_keys; i++)
        begin
            if (keys.size() > 0 && $urandom_range(0, 9) == 0)
                k = keys[$urandom_range(0, keys.size() - 1)];
            else
                k = pick_key();
            keys.insert(keys.size(), k);
            push_beat(OP_INSERT, k);
        end
        for (int i = 0; i < n_keys + 2; i++)
            push_beat(OP_PEEL, pick_key());
    endtask

    function automatic logic [COEFF_W-1:0] pick_coeffs(input int phase);
        if (phase == 1)
            return '1;
        if ($urandom_range(0, 5) == 0)
            return '0;
        return COEFF_W'({$urandom, $urandom});
    endfunction

    initial
    begin : stimulus
        int queued;
        int n;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_enable  = 1'b0;
        hold_request = 1'b0;
        fail_count   = 0;
        n_inserts = 0; n_peeled = 0; n_success = 0; n_failure = 0;
        shadow_check_coeffs = '0;
        shadow_scan = 0;
        shadow_since_peel = 0;
        for (int t = 0; t < 4; t++)
            shadow_table_coeffs[t] = '0;
        for (int i = 0; i < TOTAL_BUCKETS; i++)
        begin
            shadow_key_sums[i]   = '0;
            shadow_check_sums[i] = '0;
            shadow_counts[i]     = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with all coefficients at zero so every key shares buckets.
        push_beat(OP_PEEL, '0);                       // empty table: success
        push_beat(OP_INSERT, '0);
        push_beat(OP_PEEL, '1);                       // key zero comes out
        push_beat(OP_INSERT, 64'h8000_0000_0000_0000);
        push_beat(OP_PEEL, '0);
        push_beat(OP_INSERT, 64'h7fff_ffff_ffff_ffff);
        push_beat(OP_INSERT, 64'h7fff_ffff_ffff_ffff); // count two, sums cancel
        push_beat(OP_PEEL, '0);                       // failure after a full pass
        push_beat(OP_PEEL, '0);                       // pass already exhausted
        push_beat(OP_INSERT, '1);                     // insert restarts the scan
        push_beat(OP_PEEL, '0);
        push_beat(OP_PEEL, '0);
        wait_drained();
        write_reg(CFG_CHECK, 62'h1555_5555_5555_5555);
        write_reg(CFG_TABLE0, 62'h0000_0000_8000_0003);
        write_reg(CFG_TABLE1, 62'h0000_0001_0000_0007);
        write_reg(CFG_TABLE2, 62'h0000_0001_8000_0001);
        write_reg(CFG_TABLE3, 62'h2aaa_aaaa_aaaa_aaaa);
        push_beat(OP_INSERT, 64'h1);
        push_beat(OP_INSERT, 64'h2);
        push_beat(OP_INSERT, 64'hffff_ffff_0000_0000);
        push_beat(OP_PEEL, '0);
        push_beat(OP_PEEL, '0);
        push_beat(OP_PEEL, '0);
        push_beat(OP_PEEL, '0);
        wait_drained();

        // Random phases, each under its own hash coefficients.
        for (int ph = 1; ph <= 10; ph++)
        begin
            write_reg(CFG_CHECK, pick_coeffs(ph));
            write_reg(CFG_TABLE0, pick_coeffs(ph));
            write_reg(CFG_TABLE1, pick_coeffs(ph));
            write_reg(CFG_TABLE2, pick_coeffs(ph));
            write_reg(CFG_TABLE3, pick_coeffs(ph));
            write_reg(CFG_IDX_W'($urandom_range(5, 7)), COEFF_W'({$urandom, $urandom}));
            idle_enable = (ph < 9) && (ph % 4 != 3);
            if (ph == 2)
            begin
                hold_request = 1'b1;
                for (int i = 0; i < 40; i++)
                    push_beat(OP_INSERT, pick_key());
                for (int i = 0; i < 45; i++)
                    push_beat(OP_PEEL, '0);
            end
            queued = 0;
            while (queued < 80)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    // Noise: operations in no particular order.
                    for (int i = 0; i < 8; i++)
                        push_beat(logic'($urandom_range(0, 1)), pick_key());
                    queued += 8;
                end
                else
                begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 10);
                    push_round(n);
                    queued += 2 * n + 2;
                end
            end
            wait_drained();
        end

        $display("Covered %0d inserts, %0d peeled keys, %0d empty and %0d stuck peel passes,",
                 n_inserts, n_peeled, n_success, n_failure);
        $display("over twelve coefficient settings with random stalls and one long hold-off.");
        if (fail_count == 0)
            $display("iblt_insert_and_peel: match");
        else
            $display("iblt_insert_and_peel: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #100_000_000;
        $display("iblt_insert_and_peel: mismatch");
        $finish;
    end

endmodule
